[src/loop_trip_count_calc_unit_assert.svh]
// assertion macros used by the top-level rtl file
`ifndef LOOP_TRIP_COUNT_CALC_UNIT_ASSERT_SVH
`define LOOP_TRIP_COUNT_CALC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LTC_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ltc assertion failed");
`define LTC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ltc assertion failed");
`else
`define LTC_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define LTC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[src/ltc_pkg.sv]
`timescale 1ns / 1ps
package ltc_pkg;
  localparam int FIELD_W = 64;
  localparam int IN_DATA_W = 3 * FIELD_W;
  localparam int OP_W = 3;

  localparam logic [OP_W-1:0] OP_SLT = 3'd0;
  localparam logic [OP_W-1:0] OP_SLE = 3'd1;
  localparam logic [OP_W-1:0] OP_SGT = 3'd2;
  localparam logic [OP_W-1:0] OP_SGE = 3'd3;
  localparam logic [OP_W-1:0] OP_NE  = 3'd4;

  // how the back end turns quotient and remainder into a count
  typedef enum logic [2:0] {
    MODE_UNK    = 3'd0,
    MODE_ZERO   = 3'd1,
    MODE_CEIL   = 3'd2,
    MODE_FLOOR1 = 3'd3,
    MODE_EXACT  = 3'd4
  } mode_t;
endpackage

[src/ltc_front.sv]
`timescale 1ns / 1ps
module ltc_front import ltc_pkg::*; #(
  parameter int W = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [OP_W-1:0]      in_tuser,
  output logic                 fr_valid,
  input  logic                 fr_ready,
  output mode_t                fr_mode,
  output logic [W-1:0]         fr_diff,
  output logic [W-1:0]         fr_mag
);
  logic         valid_r, valid_nxt;
  mode_t        mode_r, mode_nxt;
  logic [W-1:0] diff_r, diff_nxt, mag_r, mag_nxt;
  logic [W-1:0] st, sp, bd;
  logic         lt, eq, step_neg, step_pos;

  assign st = in_tdata[W-1:0];
  assign sp = in_tdata[FIELD_W +: W];
  assign bd = in_tdata[2*FIELD_W +: W];
  assign lt = $signed(st) < $signed(bd);
  assign eq = (st == bd);
  assign step_neg = sp[W-1];
  assign step_pos = (sp != '0) && !sp[W-1];

  always_comb begin
    mode_nxt = MODE_UNK;
    diff_nxt = lt ? (bd - st) : (st - bd);
    mag_nxt  = step_neg ? (W'(0) - sp) : sp;
    if (sp != '0) begin
      unique case (in_tuser)
        OP_SLT: if (step_pos) mode_nxt = lt ? MODE_CEIL : MODE_ZERO;
        OP_SLE: if (step_pos) mode_nxt = (lt || eq) ? MODE_FLOOR1 : MODE_ZERO;
        OP_SGT: if (step_neg) mode_nxt = (!lt && !eq) ? MODE_CEIL : MODE_ZERO;
        OP_SGE: if (step_neg) mode_nxt = !lt ? MODE_FLOOR1 : MODE_ZERO;
        OP_NE: begin
          if (eq) mode_nxt = MODE_ZERO;
          else if ((lt && step_pos) || (!lt && step_neg)) mode_nxt = MODE_EXACT;
        end
        default: mode_nxt = MODE_UNK;
      endcase
    end
  end

  assign in_tready = !valid_r || fr_ready;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r <= mode_nxt;
      diff_r <= diff_nxt;
      mag_r  <= mag_nxt;
    end
  end

  assign fr_valid = valid_r;
  assign fr_mode  = mode_r;
  assign fr_diff  = diff_r;
  assign fr_mag   = mag_r;
endmodule

[src/ltc_queue.sv]
`timescale 1ns / 1ps
module ltc_queue #(
  parameter int DW = 131
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [DW-1:0] wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output logic [DW-1:0] rd_data
);
  // two-entry fifo
  logic [DW-1:0] mem_r [2];
  logic          wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wr_data;
  end
endmodule

[src/ltc_back.sv]
`timescale 1ns / 1ps
module ltc_back import ltc_pkg::*; #(
  parameter int W = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               bk_valid,
  output logic               bk_ready,
  input  mode_t              bk_mode,
  input  logic [W-1:0]       bk_diff,
  input  logic [W-1:0]       bk_mag,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [FIELD_W-1:0] out_tdata,
  output logic [0:0]         out_tuser
);
  // one restoring division step per stage, whole pipe stalls together
  logic         v_r    [W];
  mode_t        mode_r [W];
  logic [W-1:0] rem_r  [W];
  logic [W-1:0] dq_r   [W];
  logic [W-1:0] mag_r  [W];
  logic         en;

  logic               ov_r, ov_nxt;
  logic [FIELD_W-1:0] cnt_r, cnt_nxt;
  logic               known_r, known_nxt;

  assign en = !ov_r || out_tready;
  assign bk_ready = en;

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic         pv;
    mode_t        pmode;
    logic [W-1:0] prem, pdq, pmag;
    logic [W:0]   sh;
    logic         ge;
    if (s == 0) begin : g_first
      assign pv = bk_valid;
      assign pmode = bk_mode;
      assign prem = '0;
      assign pdq = bk_diff;
      assign pmag = bk_mag;
    end else begin : g_rest
      assign pv = v_r[s-1];
      assign pmode = mode_r[s-1];
      assign prem = rem_r[s-1];
      assign pdq = dq_r[s-1];
      assign pmag = mag_r[s-1];
    end
    assign sh = {prem, pdq[W-1]};
    assign ge = (sh >= {1'b0, pmag});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mode_r[s] <= pmode;
        rem_r[s]  <= ge ? W'(sh - {1'b0, pmag}) : W'(sh);
        dq_r[s]   <= {pdq[W-2:0], ge};
        mag_r[s]  <= pmag;
      end
    end
  end

  logic [W-1:0] q, r;
  logic [W:0]   q1;
  assign q  = dq_r[W-1];
  assign r  = rem_r[W-1];
  assign q1 = {1'b0, q} + (W+1)'(1);

  always_comb begin
    known_nxt = 1'b0;
    cnt_nxt   = '0;
    unique case (mode_r[W-1])
      MODE_ZERO: known_nxt = 1'b1;
      MODE_CEIL: begin
        known_nxt = 1'b1;
        cnt_nxt = FIELD_W'(q) + FIELD_W'(r != '0);
      end
      MODE_FLOOR1: begin
        known_nxt = 1'b1;
        // a count of 2^64 saturates
        cnt_nxt = (q1[W] && (W == FIELD_W)) ? '1 : FIELD_W'(q1);
      end
      MODE_EXACT: begin
        known_nxt = (r == '0);
        cnt_nxt = (r == '0) ? FIELD_W'(q) : '0;
      end
      default: known_nxt = 1'b0;
    endcase
  end

  assign ov_nxt = en ? v_r[W-1] : ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt_r   <= cnt_nxt;
      known_r <= known_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = cnt_r;
  assign out_tuser  = known_r;
endmodule

[src/loop_trip_count_calc_unit.sv]
`timescale 1ns / 1ps
// loop trip count calculator: each request carries a loop's continue predicate
// (in_tuser) and its signed start, step and bound (in_tdata); each result says
// whether the trip count is known (out_tuser) and gives the count (out_tdata),
// zero when unknown and saturated at all ones. one request is taken every cycle
// when the result side keeps up; a request passes through the classification
// register, the two-entry queue, DATA_WIDTH stages of a radix-2 restoring
// divider (one quotient bit per stage) and the result register. only the low
// DATA_WIDTH bits of each operand are used, read as two's complement. a
// stalled result stalls the divider pipe; the queue and the front stage
// absorb requests in the meantime
`include "loop_trip_count_calc_unit_assert.svh"
module loop_trip_count_calc_unit import ltc_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // start_value [63:0], step_value [127:64], bound_value [191:128]
  input  logic [IN_DATA_W-1:0] in_tdata,
  // operation [2:0]
  input  logic [OP_W-1:0]      in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // trip_count [63:0]
  output logic [FIELD_W-1:0]   out_tdata,
  // count_known [0]
  output logic [0:0]           out_tuser
);
  localparam int W = DATA_WIDTH;
  localparam int QW = 3 + 2 * W;

  // front stage to queue
  logic         fr_valid, fr_ready;
  mode_t        fr_mode;
  logic [W-1:0] fr_diff, fr_mag;
  // queue to divider
  logic          bk_valid, bk_ready;
  logic [QW-1:0] bk_data;
  mode_t         bk_mode;

  ltc_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr_mode  (fr_mode),
    .fr_diff  (fr_diff),
    .fr_mag   (fr_mag)
  );

  ltc_queue #(.DW(QW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(fr_valid),
    .wr_ready(fr_ready),
    .wr_data ({fr_mode, fr_diff, fr_mag}),
    .rd_valid(bk_valid),
    .rd_ready(bk_ready),
    .rd_data (bk_data)
  );

  assign bk_mode = mode_t'(bk_data[QW-1 -: 3]);

  ltc_back #(.W(W)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .bk_valid  (bk_valid),
    .bk_ready  (bk_ready),
    .bk_mode   (bk_mode),
    .bk_diff   (bk_data[2*W-1:W]),
    .bk_mag    (bk_data[W-1:0]),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // an unknown count always reads as zero
  `LTC_ASSERT_IMPL(a_unknown_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == '0)
  // the divider pipe holds while a result waits
  `LTC_ASSERT_IMPL(a_back_stall, clk, rst_n, out_tvalid && !out_tready, !bk_ready)
  // a waiting result is still there next cycle
  `LTC_ASSERT_NEXT(a_result_held, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
endmodule
